// ===== hw/rtl/tcwc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcwc_pkg;

  // Datapath widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned SMSS_W = 16;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  // Start window segment size thresholds, reset segment size and window ceiling, in bytes
  localparam logic [SMSS_W-1:0] SMSS_LARGE  = SMSS_W'(2190);
  localparam logic [SMSS_W-1:0] SMSS_MEDIUM = SMSS_W'(1095);
  localparam logic [SMSS_W-1:0] SMSS_RESET  = SMSS_W'(1460);
  localparam logic [DATA_W-1:0] WINDOW_MAX  = '1;

  // Event codes
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_ACK     = 2'd1,
    OP_CONGEST = 2'd2,
    OP_RSVD    = 2'd3
  } op_e;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_OUTST  = 5'b00010,
    ST_FLIGHT = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/tcwc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcwc_div import tcwc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] dividend_i,
  input  wire logic [DATA_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [DATA_W-1:0]      quotient_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dsr_q, dsr_d;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              fits;

  // One restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    trial = {rem_q, quo_q[DATA_W-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = (trial >= {1'b0, dsr_q});
  end

  // Sequence the steps, one quotient bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tcp_congestion_window_control_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake               | Payload
// in      | sink      | in_valid_i / in_stall_o  | opcode, ack_seq, max_sent_seq, established,
//         |           |                          | fin_sent, sacked_bytes
// out     | source    | out_valid_o / out_stall_i| window, threshold, flight_size, avoidance_mode
// cfg     | sink      | cfg_valid_i / cfg_ready_o| max_segment_size
//
// An event passes the OUTST, FLIGHT and DONE states; its result is loaded into the output
// register on leaving DONE, once that register is empty or its beat is taken. An ack in
// congestion avoidance also passes DIV, where the radix-2 divider works out smss*smss/window.
// One event is in work at a time; in_stall_o is high until its result is loaded into
// the output register, which then waits for the sink while the next event is taken.
// Reset clears window, threshold and last acked sequence and sets the segment size to 1460.
module tcp_congestion_window_control_core import tcwc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [SMSS_W-1:0] cfg_data_i,
  // events
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [DATA_W-1:0] ack_seq_i,
  input  wire logic [DATA_W-1:0] max_sent_seq_i,
  input  wire logic              established_i,
  input  wire logic              fin_sent_i,
  input  wire logic [DATA_W-1:0] sacked_bytes_i,
  // results
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [DATA_W-1:0]      window_o,
  output logic [DATA_W-1:0]      threshold_o,
  output logic [DATA_W-1:0]      flight_size_o,
  output logic                   avoidance_mode_o
);

  state_e            state_q, state_d;
  logic [SMSS_W-1:0] smss_q;
  logic [DATA_W-1:0] window_q, window_d;
  logic [DATA_W-1:0] thresh_q, thresh_d;
  logic [DATA_W-1:0] last_acked_q, last_acked_d;
  logic              out_valid_q, out_valid_d;

  // captured event
  op_e               op_q;
  logic [DATA_W-1:0] ack_q;
  logic [DATA_W-1:0] sent_q;
  logic              est_q;
  logic              fin_q;
  logic [DATA_W-1:0] sacked_q;

  logic [DATA_W-1:0] outst_q;
  logic [DATA_W-1:0] flight_q;
  logic [DATA_W-1:0] prod_q;

  logic [DATA_W-1:0] win_out_q;
  logic [DATA_W-1:0] thr_out_q;
  logic [DATA_W-1:0] flt_out_q;
  logic              avoid_out_q;

  logic              in_accept;
  logic              commit;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;

  logic [DATA_W-1:0] newly;
  logic [DATA_W-1:0] inc;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] start_win;
  logic [DATA_W-1:0] half;
  logic [DATA_W-1:0] floor2;
  logic [DATA_W-1:0] smss_ext;

  assign in_accept = in_valid_i && !in_stall_o;
  assign commit    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign div_start = (state_q == ST_FLIGHT) && (op_q == OP_ACK) && (window_q > thresh_q);

  // Divider for the avoidance increment
  tcwc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (window_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_OUTST;
      ST_OUTST:  state_d = ST_FLIGHT;
      ST_FLIGHT: state_d = div_start ? ST_DIV : ST_DONE;
      ST_DIV:    if (div_done) state_d = ST_DONE;
      ST_DONE:   if (commit) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Window update for the event
  always_comb begin
    smss_ext = DATA_W'(smss_q);
    newly    = ack_q - last_acked_q;
    if (window_q > thresh_q) begin
      inc = (div_quo == '0) ? DATA_W'(1) : div_quo;
    end else begin
      inc = (newly < smss_ext) ? newly : smss_ext;
    end
    sum = {1'b0, window_q} + {1'b0, inc};

    if (smss_q > SMSS_LARGE) begin
      start_win = DATA_W'({smss_q, 1'b0});
    end else if (smss_q > SMSS_MEDIUM) begin
      start_win = DATA_W'({smss_q, 1'b0}) + smss_ext;
    end else begin
      start_win = DATA_W'({smss_q, 2'b00});
    end

    half   = flight_q >> 1;
    floor2 = DATA_W'({smss_q, 1'b0});

    window_d     = window_q;
    thresh_d     = thresh_q;
    last_acked_d = last_acked_q;
    if (commit) begin
      unique case (op_q)
        OP_START: begin
          window_d     = start_win;
          thresh_d     = start_win;
          last_acked_d = ack_q;
        end
        OP_ACK: begin
          window_d     = sum[DATA_W] ? WINDOW_MAX : sum[DATA_W-1:0];
          last_acked_d = ack_q;
        end
        OP_CONGEST: begin
          thresh_d = (half > floor2) ? half : floor2;
        end
        OP_RSVD: begin
          window_d = window_q;
        end
        default: begin
          window_d = window_q;
        end
      endcase
    end
  end

  // Output beat handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (commit) out_valid_d = 1'b1;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      smss_q       <= SMSS_RESET;
      window_q     <= '0;
      thresh_q     <= '0;
      last_acked_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      window_q     <= window_d;
      thresh_q     <= thresh_d;
      last_acked_q <= last_acked_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i) smss_q <= cfg_data_i;
    end
  end

  // Payload: capture beat, flight size, product, result
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= op_e'(opcode_i);
      ack_q    <= ack_seq_i;
      sent_q   <= max_sent_seq_i;
      est_q    <= established_i;
      fin_q    <= fin_sent_i;
      sacked_q <= sacked_bytes_i;
    end
    if (state_q == ST_OUTST) begin
      outst_q <= sent_q - ack_q + DATA_W'(!est_q) + DATA_W'(fin_q);
      prod_q  <= DATA_W'(smss_q) * DATA_W'(smss_q);
    end
    if (state_q == ST_FLIGHT) begin
      flight_q <= (sacked_q <= outst_q) ? (outst_q - sacked_q) : '0;
    end
    if (commit) begin
      win_out_q   <= window_d;
      thr_out_q   <= thresh_d;
      flt_out_q   <= flight_q;
      avoid_out_q <= (window_d > thresh_d);
    end
  end

  assign cfg_ready_o      = 1'b1;
  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign window_o         = win_out_q;
  assign threshold_o      = thr_out_q;
  assign flight_size_o    = flt_out_q;
  assign avoidance_mode_o = avoid_out_q;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tcwc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam logic [15:0] SEG_RESET     = 16'd1460;
  localparam logic [31:0] SEG_LARGE     = 32'd2190;
  localparam logic [31:0] SEG_MEDIUM    = 32'd1095;

  typedef struct packed {
    logic [DATA_W-1:0] window;
    logic [DATA_W-1:0] threshold;
    logic [DATA_W-1:0] flight;
    logic              avoid;
  } window_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [SMSS_W-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        opcode_i;
  logic [DATA_W-1:0] ack_seq_i;
  logic [DATA_W-1:0] max_sent_seq_i;
  logic              established_i;
  logic              fin_sent_i;
  logic [DATA_W-1:0] sacked_bytes_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [DATA_W-1:0] window_o;
  logic [DATA_W-1:0] threshold_o;
  logic [DATA_W-1:0] flight_size_o;
  logic              avoidance_mode_o;

  // Shadow of the connection state
  logic [SMSS_W-1:0] seg_size;
  logic [DATA_W-1:0] cwnd;
  logic [DATA_W-1:0] ssthresh;
  logic [DATA_W-1:0] acked_seq;

  window_result_t expected_windows[$];
  int unsigned    mismatch_count;
  int unsigned    cycle_count;
  int unsigned    stall_left;
  bit             in_idle;
  bit             out_idle;

  tcp_congestion_window_control_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .ack_seq_i        (ack_seq_i),
    .max_sent_seq_i   (max_sent_seq_i),
    .established_i    (established_i),
    .fin_sent_i       (fin_sent_i),
    .sacked_bytes_i   (sacked_bytes_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .window_o         (window_o),
    .threshold_o      (threshold_o),
    .flight_size_o    (flight_size_o),
    .avoidance_mode_o (avoidance_mode_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Apply one event to the shadow state and return the window report it produces
  function automatic window_result_t next_window_state(op_e op, logic [31:0] una,
      logic [31:0] snd_max, logic est, logic fin, logic [31:0] sacked);
    logic [31:0]    seg32;
    logic [31:0]    outstanding;
    logic [31:0]    flight;
    logic [31:0]    newly;
    logic [31:0]    incr;
    logic [31:0]    half;
    logic [31:0]    floor2;
    logic [63:0]    quot;
    logic [32:0]    sum;
    window_result_t res;
    seg32 = {16'd0, seg_size};
    outstanding = snd_max - una;
    if (!est) outstanding = outstanding + 32'd1;
    if (fin) outstanding = outstanding + 32'd1;
    flight = (sacked <= outstanding) ? outstanding - sacked : 32'd0;
    case (op)
      OP_START: begin
        if (seg32 > SEG_LARGE) cwnd = seg32 * 32'd2;
        else if (seg32 > SEG_MEDIUM) cwnd = seg32 * 32'd3;
        else cwnd = seg32 * 32'd4;
        ssthresh  = cwnd;
        acked_seq = una;
      end
      OP_ACK: begin
        newly = una - acked_seq;
        if (cwnd > ssthresh) begin
          quot = ({32'd0, seg32} * {32'd0, seg32}) / {32'd0, cwnd};
          incr = (quot == 64'd0) ? 32'd1 : quot[31:0];
        end else begin
          incr = (newly < seg32) ? newly : seg32;
        end
        sum  = {1'b0, cwnd} + {1'b0, incr};
        cwnd = sum[32] ? '1 : sum[31:0];
        acked_seq = una;
      end
      OP_CONGEST: begin
        half     = flight >> 1;
        floor2   = seg32 << 1;
        ssthresh = (half > floor2) ? half : floor2;
      end
      default: ;
    endcase
    res.window    = cwnd;
    res.threshold = ssthresh;
    res.flight    = flight;
    res.avoid     = (cwnd > ssthresh);
    return res;
  endfunction

  // Present one event beat and record its expected report once accepted
  task automatic send_event(op_e op, logic [31:0] una, logic [31:0] snd_max,
      logic est, logic fin, logic [31:0] sacked);
    int unsigned gap;
    gap = in_idle ? $urandom_range(0, 19) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    opcode_i       = op;
    ack_seq_i      = una;
    max_sent_seq_i = snd_max;
    established_i  = est;
    fin_sent_i     = fin;
    sacked_bytes_i = sacked;
    in_valid_i     = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_windows.push_back(next_window_state(op, una, snd_max, est, fin, sacked));
  endtask

  // Drop valid, drain all reports, then let the block go quiet
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_windows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_segment_size(logic [15:0] value);
    settle_idle();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    seg_size = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Release the result stall after the drawn number of cycles
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // Check every report beat against the oldest pending expectation
  always @(posedge clk_i) begin
    window_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_windows.size() == 0) begin
        $error("report beat with no pending event");
        mismatch_count++;
      end else begin
        exp_res = expected_windows.pop_front();
        compare_field("window", exp_res.window, window_o);
        compare_field("threshold", exp_res.threshold, threshold_o);
        compare_field("flight_size", exp_res.flight, flight_size_o);
        compare_field("avoidance_mode", 32'(exp_res.avoid), 32'(avoidance_mode_o));
      end
      stall_left = out_idle ? $urandom_range(0, 19) : 0;
    end
  end

  // Cover flight arithmetic wraps, sacked limits, stray opcodes and both growth modes
  task automatic test_event_basics();
    in_idle  = 1'b1;
    out_idle = 1'b1;
    send_event(OP_ACK, 32'd1000, 32'd1000, 1'b0, 1'b1, 32'd0);
    send_event(OP_RSVD, 32'h0000_0010, 32'h0000_000F, 1'b0, 1'b1, 32'd0);
    send_event(OP_START, 32'hFFFF_FF00, 32'h0000_1000, 1'b1, 1'b0, 32'd0);
    send_event(OP_ACK, 32'h0001_8000, 32'h0002_0000, 1'b1, 1'b0, 32'h100);
    send_event(OP_ACK, 32'h0001_8100, 32'h0002_0000, 1'b1, 1'b0, 32'd0);
    send_event(OP_CONGEST, 32'h0001_8100, 32'h0001_80FF, 1'b1, 1'b0, 32'd0);
    send_event(OP_ACK, 32'h0001_8107, 32'h0002_0000, 1'b1, 1'b0, 32'd0);
    send_event(OP_ACK, 32'h0000_0005, 32'h0000_9000, 1'b1, 1'b0, 32'd0);
    send_event(OP_CONGEST, 32'd100, 32'd200, 1'b1, 1'b0, 32'd500);
    send_event(OP_CONGEST, 32'd100, 32'd200, 1'b0, 1'b1, 32'd102);
    send_event(OP_CONGEST, 32'd0, 32'h8000_0000, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_event(OP_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_event(OP_START, 32'd0, 32'd0, 1'b0, 1'b0, 32'd0);
  endtask

  // Hit both sides of each start window size boundary
  task automatic test_start_sizes();
    logic [15:0] sizes[4];
    logic [31:0] una;
    sizes = '{16'd1095, 16'd1096, 16'd2190, 16'd2191};
    in_idle  = 1'b0;
    out_idle = 1'b0;
    foreach (sizes[i]) begin
      write_segment_size(sizes[i]);
      una = $urandom;
      send_event(OP_START, una, una + 32'd50000, 1'b1, 1'b0, 32'd0);
      send_event(OP_ACK, una + 32'd40000, una + 32'd60000, 1'b1, 1'b0, 32'd0);
    end
  endtask

  // Zero segment size, then a one-byte window blown up by the largest segment size.
  // Reaching the saturation point from here needs ~131k more acks, so stop short.
  task automatic test_window_climb();
    logic [31:0] una;
    una = 32'hFFFF_FFF0;
    in_idle  = 1'b1;
    out_idle = 1'b0;
    write_segment_size(16'd0);
    send_event(OP_START, una, una + 32'd100, 1'b1, 1'b0, 32'd0);
    write_segment_size(16'd1);
    send_event(OP_ACK, una + 32'd1, una + 32'd100, 1'b1, 1'b0, 32'd0);
    write_segment_size(16'hFFFF);
    send_event(OP_ACK, una + 32'd2, una + 32'd100, 1'b1, 1'b0, 32'd0);
    send_event(OP_ACK, una + 32'd3, una + 32'd100, 1'b1, 1'b1, 32'd0);
    send_event(OP_CONGEST, una + 32'd3, una + 32'h0100_0000, 1'b1, 1'b0, 32'd7);
  endtask

  // Mostly well-formed connections with random content, plus noise
  task automatic test_random_traffic();
    int unsigned sizes[9];
    int unsigned seg;
    int unsigned kind;
    int unsigned pick;
    logic [31:0] una;
    logic [31:0] snd_max;
    logic [31:0] sacked;
    logic        est;
    logic        fin;
    sizes = '{1, 65535, 1460, 536, 1095, 1096, 2190, 2191, 0};
    sizes[8] = $urandom_range(1, 65535);
    foreach (sizes[ph]) begin
      seg = sizes[ph];
      write_segment_size(seg[15:0]);
      in_idle  = (ph % 4 == 0) || (ph % 4 == 2);
      out_idle = (ph % 4 == 0) || (ph % 4 == 3);
      una = $urandom;
      send_event(OP_START, una, una + $urandom_range(0, 16 * seg + 16), 1'b1, 1'b0, 32'd0);
      for (int n = 1; n < 50; n++) begin
        kind = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        est  = ($urandom_range(0, 9) != 0);
        fin  = ($urandom_range(0, 9) == 0);
        if (pick < 60) sacked = 32'd0;
        else if (pick < 90) sacked = $urandom_range(0, 8 * seg + 8);
        else sacked = $urandom;
        if (kind < 6) begin
          una = $urandom;
          snd_max = una + $urandom_range(0, 16 * seg + 16);
          send_event(OP_START, una, snd_max, est, fin, sacked);
        end else if (kind < 70) begin
          pick = $urandom_range(0, 99);
          if (pick < 10) una = una;
          else if (pick < 85) una = una + $urandom_range(1, 3 * seg + 1);
          else una = una + $urandom;
          snd_max = una + $urandom_range(0, 16 * seg + 16);
          send_event(OP_ACK, una, snd_max, est, fin, sacked);
        end else if (kind < 82) begin
          if ($urandom_range(0, 9) < 7) snd_max = una + $urandom_range(0, 32 * seg + 32);
          else snd_max = una + $urandom;
          send_event(OP_CONGEST, una, snd_max, est, fin, sacked);
        end else if (kind < 87) begin
          send_event(OP_RSVD, una, una + $urandom_range(0, 4 * seg), est, fin, sacked);
        end else begin
          send_event(op_e'($urandom_range(0, 3)), $urandom, $urandom,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
        end
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_START;
    ack_seq_i      = '0;
    max_sent_seq_i = '0;
    established_i  = 1'b0;
    fin_sent_i     = 1'b0;
    sacked_bytes_i = '0;
    out_stall_i    = 1'b0;
    stall_left     = 0;
    mismatch_count = 0;
    in_idle        = 1'b0;
    out_idle       = 1'b0;
    seg_size       = SEG_RESET;
    cwnd           = '0;
    ssthresh       = '0;
    acked_seq      = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_event_basics();
    test_start_sizes();
    test_window_climb();
    test_random_traffic();

    settle_idle();
    if (expected_windows.size() != 0) begin
      $error("%0d expected reports never arrived", expected_windows.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== tcp_congestion_window_control_core.f =====
hw/rtl/tcwc_pkg.sv
hw/rtl/tcwc_div.sv
hw/rtl/tcp_congestion_window_control_core.sv
tb/tb_top.sv
